### rtl/barcode_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Barcode frame receiver assertion macros
// Concurrent check helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BARCODE_FRAME_RECEIVER_MACROS_SVH
`define BARCODE_FRAME_RECEIVER_MACROS_SVH

// condition holds in the same cycle
`define BFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define BFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared constants and types of the barcode frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 6;
  localparam int CNT_W         = 8;
  localparam int TICK_W        = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [LEN_W-1:0] MIN_LEN_RST     = LEN_W'(3);
  localparam logic [CNT_W-1:0] FRAME_LIMIT_RST = CNT_W'(8);

  localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_P   = 8'h50;
  localparam logic [BYTE_W-1:0] BYTE_S   = 8'h53;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } bfr_state_t;

  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic start;   // accepted item completes a frame
    logic load;    // move one buffered byte into the output register
  } bfr_cmd_t;

  typedef struct packed {
    logic frame_done;  // current input would complete a frame
    logic out_free;    // output register can take a byte
    logic rd_last;     // byte being read is the frame's last
  } bfr_status_t;

endpackage

### rtl/bfr_if.sv
// ----------------------------------------------------------------------------
// bfr_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface bfr_in_if import bfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] rx_byte;
  logic [TICK_W-1:0] time_tick;

  modport source(output valid, cmd, rx_byte, time_tick, input ready);
  modport sink(input valid, cmd, rx_byte, time_tick, output ready);
endinterface

interface bfr_out_if import bfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  frame_length;
  logic [TICK_W-1:0] frame_stamp;
  logic [CNT_W-1:0]  frame_number;
  logic              last;

  modport source(output valid, data_byte, byte_index, frame_length, frame_stamp,
                 frame_number, last, input ready);
  modport sink(input valid, data_byte, byte_index, frame_length, frame_stamp,
               frame_number, last, output ready);
endinterface

interface bfr_cfg_if import bfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

### rtl/bfr_ctrl.sv
// ----------------------------------------------------------------------------
// bfr_ctrl
// Controller: takes items while idle, then steps a completed frame out.
// ----------------------------------------------------------------------------
module bfr_ctrl import bfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  bfr_status_t status,
  output logic        in_ready,
  output bfr_cmd_t    cmd
);

  bfr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.start  = in_valid && status.frame_done;
        if (cmd.start) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.load = status.out_free;
        if (cmd.load && status.rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/bfr_dpath.sv
// ----------------------------------------------------------------------------
// bfr_dpath
// Datapath: frame collection state, line buffer, registers, output register.
// ----------------------------------------------------------------------------
module bfr_dpath import bfr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfr_cmd_t              cmd,
  output bfr_status_t           status,
  input  logic                  in_cmd,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  input  logic [TICK_W-1:0]     in_time_tick,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_reg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_data_byte,
  output logic [LEN_W-1:0]      out_byte_index,
  output logic [LEN_W-1:0]      out_frame_length,
  output logic [TICK_W-1:0]     out_frame_stamp,
  output logic [CNT_W-1:0]      out_frame_number,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(BUF_DEPTH);

  logic [BYTE_W-1:0] line_buf_mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  logic [IDX_W-1:0]  collect_r, collect_nxt;
  logic              cr_seen_r, cr_seen_nxt;
  logic [BYTE_W-1:0] byte0_r, byte0_nxt;
  logic [BYTE_W-1:0] byte1_r, byte1_nxt;
  logic [CNT_W-1:0]  frames_r, frames_nxt;
  logic [LEN_W-1:0]  min_len_r, min_len_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]  flen_r;
  logic [TICK_W-1:0] stamp_r;
  logic [CNT_W-1:0]  fnum_r;

  logic [BYTE_W-1:0] out_data_r;
  logic [LEN_W-1:0]  out_idx_r;
  logic [LEN_W-1:0]  out_flen_r;
  logic [TICK_W-1:0] out_stamp_r;
  logic [CNT_W-1:0]  out_fnum_r;
  logic              out_last_r;

  logic             is_cr, is_lf, is_stx, echo, cr_drop, wr_en, wrap;
  logic [IDX_W:0]   pos_inc;

  always_comb begin
    is_cr   = (in_rx_byte == BYTE_CR);
    is_lf   = (in_rx_byte == BYTE_LF);
    is_stx  = (in_rx_byte == BYTE_STX);
    echo    = (byte0_r == BYTE_P) && (byte1_r == BYTE_S);
    cr_drop = (collect_r == '0) || (LEN_W'(collect_r) < min_len_r) || echo;
    wr_en   = cmd.accept && !in_cmd && !cr_seen_r && !is_cr && !is_stx && !is_lf;
    pos_inc = {1'b0, collect_r} + (IDX_W+1)'(1);
    wrap    = (pos_inc >= (IDX_W+1)'(BUF_DEPTH));

    status.frame_done = !in_cmd && cr_seen_r && is_lf && (frames_r < limit_r);
    status.out_free   = !out_valid_r || out_ready;
    status.rd_last    = (rd_idx_r == flen_r - IDX_W'(1));
  end

  always_comb begin
    collect_nxt = collect_r;
    cr_seen_nxt = cr_seen_r;
    byte0_nxt   = byte0_r;
    byte1_nxt   = byte1_r;
    frames_nxt  = frames_r;
    if (cmd.accept) begin
      if (in_cmd) begin
        collect_nxt = '0;
        cr_seen_nxt = 1'b0;
        byte0_nxt   = '0;
        byte1_nxt   = '0;
        frames_nxt  = '0;
      end else if (cr_seen_r) begin
        if (status.frame_done) begin
          frames_nxt = frames_r + CNT_W'(1);
        end
        collect_nxt = '0;
        cr_seen_nxt = 1'b0;
      end else if (is_cr) begin
        if (cr_drop) begin
          collect_nxt = '0;
        end else begin
          cr_seen_nxt = 1'b1;
        end
      end else if (wr_en) begin
        if (collect_r == IDX_W'(0)) begin
          byte0_nxt = in_rx_byte;
        end
        if (collect_r == IDX_W'(1)) begin
          byte1_nxt = in_rx_byte;
        end
        collect_nxt = wrap ? '0 : pos_inc[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    min_len_nxt = min_len_r;
    limit_nxt   = limit_r;
    if (cfg_valid) begin
      case (cfg_reg_index)
        REG_MIN_LENGTH:  min_len_nxt = cfg_wr_data[LEN_W-1:0];
        REG_FRAME_LIMIT: limit_nxt   = cfg_wr_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.start) begin
      rd_idx_nxt = '0;
    end else if (cmd.load) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_buf_mem[collect_r] <= in_rx_byte;
    end
    rd_data_r <= line_buf_mem[rd_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collect_r   <= '0;
      cr_seen_r   <= 1'b0;
      byte0_r     <= '0;
      byte1_r     <= '0;
      frames_r    <= '0;
      min_len_r   <= MIN_LEN_RST;
      limit_r     <= FRAME_LIMIT_RST;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      collect_r   <= collect_nxt;
      cr_seen_r   <= cr_seen_nxt;
      byte0_r     <= byte0_nxt;
      byte1_r     <= byte1_nxt;
      frames_r    <= frames_nxt;
      min_len_r   <= min_len_nxt;
      limit_r     <= limit_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame latch and output register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      flen_r  <= collect_r;
      stamp_r <= in_time_tick;
      fnum_r  <= frames_r;
    end
    if (cmd.load) begin
      out_data_r  <= rd_data_r;
      out_idx_r   <= LEN_W'(rd_idx_r);
      out_flen_r  <= LEN_W'(flen_r);
      out_stamp_r <= stamp_r;
      out_fnum_r  <= fnum_r;
      out_last_r  <= status.rd_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_byte_index   = out_idx_r;
  assign out_frame_length = out_flen_r;
  assign out_frame_stamp  = out_stamp_r;
  assign out_frame_number = out_fnum_r;
  assign out_last         = out_last_r;

endmodule

### rtl/barcode_frame_receiver.sv
// ----------------------------------------------------------------------------
// barcode_frame_receiver
// Collects scanner serial bytes into frames and streams out accepted frames.
// ----------------------------------------------------------------------------
// A byte item or a clear item is taken whenever the block is idle. An LF
// that completes a frame starts a readout: the block then takes no item
// while the frame's bytes leave the line buffer through its registered
// read port, one per cycle when the output is not stalled; a stall holds
// the readout. The last byte may still wait in the output register while
// the next item is taken. Register writes are taken every cycle. No
// clearing pass follows reset.
`include "barcode_frame_receiver_macros.svh"

module barcode_frame_receiver import bfr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfr_cfg_if.sink   cfg_ch,
  bfr_in_if.sink    in_ch,
  bfr_out_if.source out_ch
);

  bfr_cmd_t    cmd;
  bfr_status_t status;

  assign cfg_ch.ready = 1'b1;

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  bfr_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_cmd           (in_ch.cmd),
    .in_rx_byte       (in_ch.rx_byte),
    .in_time_tick     (in_ch.time_tick),
    .cfg_valid        (cfg_ch.valid),
    .cfg_reg_index    (cfg_ch.reg_index),
    .cfg_wr_data      (cfg_ch.wr_data),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_data_byte    (out_ch.data_byte),
    .out_byte_index   (out_ch.byte_index),
    .out_frame_length (out_ch.frame_length),
    .out_frame_stamp  (out_ch.frame_stamp),
    .out_frame_number (out_ch.frame_number),
    .out_last         (out_ch.last)
  );

  `BFR_ASSERT_NOW(a_last_pos, out_ch.valid, out_ch.last == (out_ch.byte_index == out_ch.frame_length - 1), "last flag off the final byte")
  `BFR_ASSERT_NOW(a_idx_range, out_ch.valid, out_ch.byte_index < out_ch.frame_length, "byte index past frame length")
  `BFR_ASSERT_NEXT(a_reopen, cmd.load && status.rd_last, in_ch.ready, "input not reopened after frame")

endmodule
